// ===== rtl/i4dq_pkg.sv =====
package i4dq_pkg;

    localparam int NIBBLE_W  = 4;
    localparam int LANE_W    = 3;
    localparam int WORD_W    = 32;
    localparam int DIFF_W    = 5;
    localparam int PROD_W    = 28;
    localparam int LEAD_W    = 5;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] CFG_FORMAT_MODE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ZERO_BIAS   = 2'd1;

    localparam logic FMT_AWQ  = 1'b0;
    localparam logic FMT_GPTQ = 1'b1;

    localparam logic [3:0]  NIBBLE_MASK = 4'hF;
    localparam logic [7:0]  EXP_ALL_ONES = 8'hFF;
    localparam logic [15:0] BF16_QNAN    = 16'h7FC0;
    localparam logic [15:0] BF16_QBIT    = 16'h0040;
    localparam logic [14:0] BF16_INF_MAG = 15'h7F80;

    typedef logic [LANE_W-1:0] t_lane;

    typedef struct packed {
        logic signed [DIFF_W-1:0] diff;
        logic [WORD_W-1:0]        scale;
    } t_item;

    typedef struct packed {
        logic       full;
        logic       empty;
        logic [1:0] level;
    } t_qstat;

    function automatic t_lane awq_pos(input t_lane lane);
        t_lane pos;
        case (lane)
            3'd0: pos = 3'd0;
            3'd1: pos = 3'd4;
            3'd2: pos = 3'd1;
            3'd3: pos = 3'd5;
            3'd4: pos = 3'd2;
            3'd5: pos = 3'd6;
            3'd6: pos = 3'd3;
            3'd7: pos = 3'd7;
            default: pos = 3'd0;
        endcase
        return pos;
    endfunction

    function automatic logic [NIBBLE_W-1:0] pick_nibble(input logic [WORD_W-1:0] word,
                                                        input t_lane pos);
        return NIBBLE_W'((word >> {pos, 2'b00}) & {{(WORD_W-NIBBLE_W){1'b0}}, NIBBLE_MASK});
    endfunction

endpackage

// ===== rtl/i4dq_front.sv =====
module i4dq_front
    import i4dq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic [WORD_W-1:0]    i_weight_word,
    input  logic [WORD_W-1:0]    i_zero_word,
    input  logic [WORD_W-1:0]    i_scale_bits,
    input  logic [LANE_W-1:0]    i_column_lane,
    input  logic [LANE_W-1:0]    i_row_lane,
    output t_item                o_item
);

    logic r_format_mode;
    logic r_zero_bias;

    logic [NIBBLE_W-1:0] w_nib;
    logic [NIBBLE_W-1:0] z_nib;
    logic [DIFF_W-1:0]   z_eff;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_format_mode <= FMT_AWQ;
            r_zero_bias   <= 1'b0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_FORMAT_MODE: r_format_mode <= i_cfg_data;
                CFG_ZERO_BIAS:   r_zero_bias   <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        if (r_format_mode == FMT_AWQ) begin
            w_nib = pick_nibble(i_weight_word, awq_pos(i_column_lane));
            z_nib = pick_nibble(i_zero_word, awq_pos(i_column_lane));
            z_eff = {1'b0, z_nib};
        end else begin
            w_nib = pick_nibble(i_weight_word, i_row_lane);
            z_nib = pick_nibble(i_zero_word, i_column_lane);
            z_eff = {1'b0, z_nib} + {{(DIFF_W-1){1'b0}}, r_zero_bias};
        end
        o_item.diff  = $signed({1'b0, w_nib} - z_eff);
        o_item.scale = i_scale_bits;
    end

endmodule

// ===== rtl/i4dq_queue.sv =====
module i4dq_queue
    import i4dq_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_item  i_item,
    input  logic   i_pop,
    output t_item  o_item,
    output t_qstat o_stat
);

    t_item      r_mem [2];
    logic       r_wp;
    logic       r_rp;
    logic [1:0] r_level;
    logic       do_push;
    logic       do_pop;

    assign do_push = i_push && (r_level != 2'd2);
    assign do_pop  = i_pop && (r_level != 2'd0);

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_item;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp    <= 1'b0;
            r_rp    <= 1'b0;
            r_level <= 2'd0;
        end else begin
            if (do_push) begin
                r_wp <= ~r_wp;
            end
            if (do_pop) begin
                r_rp <= ~r_rp;
            end
            r_level <= r_level + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    assign o_item       = r_mem[r_rp];
    assign o_stat.full  = (r_level == 2'd2);
    assign o_stat.empty = (r_level == 2'd0);
    assign o_stat.level = r_level;

endmodule

// ===== rtl/i4dq_back.sv =====
module i4dq_back
    import i4dq_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_avail,
    input  t_item       i_item,
    output logic        o_pop,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [15:0] o_bf16
);

    logic              r_v1;
    logic              r_sign;
    logic              r_special;
    logic [15:0]       r_spec_val;
    logic [PROD_W-1:0] r_prod;
    logic [7:0]        r_exp;
    logic              r_ov;
    logic [15:0]       r_out;

    logic              en1;
    logic              en2;
    logic              s_sign;
    logic [DIFF_W-1:0] s_mag;
    logic [7:0]        s_e;
    logic [22:0]       s_f;
    logic [23:0]       s_m;
    logic              s_special;
    logic [15:0]       s_spec_val;

    logic [LEAD_W-1:0] lead;
    logic signed [9:0] xexp;
    logic [2:0]        sh;
    logic [23:0]       keep;
    logic              guard;
    logic              sticky;
    logic              up;
    logic [30:0]       fmag;
    logic [31:0]       sub_bits;
    logic [30:0]       rmag;

    assign en2   = !r_ov || !i_stall;
    assign en1   = !r_v1 || en2;
    assign o_pop = i_avail && en1;

    always_comb begin
        s_e        = i_item.scale[30:23];
        s_f        = i_item.scale[22:0];
        s_sign     = i_item.diff[DIFF_W-1] ^ i_item.scale[31];
        s_mag      = i_item.diff[DIFF_W-1] ? (~i_item.diff + 1'b1) : i_item.diff;
        s_m        = {(s_e != 8'd0), s_f};
        s_special  = 1'b1;
        s_spec_val = {s_sign, 15'd0};
        if (s_e == EXP_ALL_ONES && s_f != 23'd0) begin
            s_spec_val = i_item.scale[31:16] | BF16_QBIT;
        end else if (s_e == EXP_ALL_ONES && s_mag == '0) begin
            s_spec_val = BF16_QNAN;
        end else if (s_e == EXP_ALL_ONES) begin
            s_spec_val = {s_sign, BF16_INF_MAG};
        end else if (s_mag == '0 || s_m == 24'd0) begin
            s_spec_val = {s_sign, 15'd0};
        end else begin
            s_special = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) begin
            r_sign     <= s_sign;
            r_special  <= s_special;
            r_spec_val <= s_spec_val;
            r_prod     <= {{(PROD_W-DIFF_W){1'b0}}, s_mag} * {{(PROD_W-24){1'b0}}, s_m};
            r_exp      <= (s_e == 8'd0) ? 8'd1 : s_e;
        end
    end

    always_comb begin
        lead = '0;
        for (int k = 0; k < PROD_W; k++) begin
            if (r_prod[k]) begin
                lead = LEAD_W'(k);
            end
        end
        xexp     = $signed({2'b00, r_exp}) + $signed({5'b00000, lead}) - 10'sd23;
        sh       = (lead > 5'd23) ? 3'(lead - 5'd23) : 3'd0;
        guard    = 1'b0;
        sticky   = 1'b0;
        if (lead > 5'd23) begin
            keep  = 24'(r_prod >> sh);
            guard = r_prod[sh - 3'd1];
            for (int k = 0; k < 3; k++) begin
                if (k < int'(sh) - 1 && r_prod[k]) begin
                    sticky = 1'b1;
                end
            end
        end else begin
            keep = 24'(r_prod << (5'd23 - lead));
        end
        up       = guard && (sticky || keep[0]);
        sub_bits = 32'({4'd0, r_prod} << (r_exp - 8'd1));
        if (xexp >= 10'sd255) begin
            fmag = {8'hFF, 23'd0};
        end else if (xexp >= 10'sd1) begin
            fmag = {xexp[7:0], keep[22:0]} + {30'd0, up};
        end else begin
            fmag = sub_bits[30:0];
        end
        rmag = fmag + 31'h7FFF + {30'd0, fmag[16]};
    end

    always_ff @(posedge i_clk) begin
        if (en2 && r_v1) begin
            r_out <= r_special ? r_spec_val : {r_sign, rmag[30:16]};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_ov <= 1'b0;
        end else begin
            if (en1) begin
                r_v1 <= i_avail;
            end
            if (en2) begin
                r_ov <= r_v1;
            end
        end
    end

    assign o_valid = r_ov;
    assign o_bf16  = r_out;

endmodule

// ===== rtl/int4_weight_dequant_bf16_unit.sv =====
// int4 weight dequantizer: one packed 4-bit weight to one bf16 value.
// Input channel: i_in_valid / o_in_stall with weight word, zero word,
// fp32 scale and column/row lanes. A transaction is taken on a clock edge
// with valid high and stall low.
// Output channel: o_out_valid / i_out_stall with o_bf16_value.
// Config channel: i_cfg_valid / o_cfg_ready (always ready); index 0 is the
// format mode (AWQ or GPTQ), index 1 the GPTQ zero bias. Other indexes drop.
// Each input taken is written into the queue, then goes through the multiply
// stage, then the round stage into the output register.
// Throughput: one transaction per cycle while the output is not stalled, set by
// the multiply and round pipeline behind a 2-entry queue.
// Stall: o_in_stall rises only when the queue is full; with the output
// stalled the pipeline holds and the queue fills, then input stalls.
// Reset (i_rst_n low, synchronous): queue and pipeline empty, both config
// registers cleared to 0.
module int4_weight_dequant_bf16_unit
    import i4dq_pkg::*;
(
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic                 i_cfg_data,
    input  logic                 i_in_valid,
    output logic                 o_in_stall,
    input  logic [WORD_W-1:0]    i_weight_word,
    input  logic [WORD_W-1:0]    i_zero_word,
    input  logic [WORD_W-1:0]    i_scale_bits,
    input  logic [LANE_W-1:0]    i_column_lane,
    input  logic [LANE_W-1:0]    i_row_lane,
    output logic                 o_out_valid,
    input  logic                 i_out_stall,
    output logic [15:0]          o_bf16_value
);

    t_item  front_item;
    t_item  head_item;
    t_qstat qstat;
    logic   pop;
    logic   push;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = qstat.full;
    assign push        = i_in_valid && !qstat.full;

    i4dq_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .i_weight_word (i_weight_word),
        .i_zero_word   (i_zero_word),
        .i_scale_bits  (i_scale_bits),
        .i_column_lane (i_column_lane),
        .i_row_lane    (i_row_lane),
        .o_item        (front_item)
    );

    i4dq_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_item  (front_item),
        .i_pop   (pop),
        .o_item  (head_item),
        .o_stat  (qstat)
    );

    i4dq_back u_back (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_avail (!qstat.empty),
        .i_item  (head_item),
        .o_pop   (pop),
        .o_valid (o_out_valid),
        .i_stall (i_out_stall),
        .o_bf16  (o_bf16_value)
    );

    a_queue_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(qstat.full && qstat.empty))
        else $error("queue full and empty at once");

    a_queue_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        qstat.level != 2'd3)
        else $error("queue level out of range");

    a_queue_push: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (push && !pop && qstat.empty) |=> (qstat.level == 2'd1))
        else $error("queue lost a transaction");

endmodule

// ===== bench/testbench.sv =====
module testbench;
    import i4dq_pkg::*;

    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;
    localparam int STUCK_LIMIT = 4000;
    localparam int LONG_HOLD   = 300;
    localparam int PHASE_ITEMS = 283;

    typedef struct {
        logic [WORD_W-1:0] weight_word;
        logic [WORD_W-1:0] zero_word;
        logic [WORD_W-1:0] scale_bits;
        logic [LANE_W-1:0] column_lane;
        logic [LANE_W-1:0] row_lane;
    } weight_txn_t;

    logic                 i_clk;
    logic                 i_rst_n;
    logic                 i_cfg_valid;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic                 i_cfg_data;
    logic                 i_in_valid;
    logic                 o_in_stall;
    logic [WORD_W-1:0]    i_weight_word;
    logic [WORD_W-1:0]    i_zero_word;
    logic [WORD_W-1:0]    i_scale_bits;
    logic [LANE_W-1:0]    i_column_lane;
    logic [LANE_W-1:0]    i_row_lane;
    logic                 o_out_valid;
    logic                 i_out_stall;
    logic [15:0]          o_bf16_value;

    weight_txn_t   pending_weights[$];
    weight_txn_t   offered;
    logic [15:0]   bf16_expect[$];
    logic          mode_copy;
    logic          bias_copy;
    int            err_count;
    int            stuck_cycles;
    int            in_accepts;
    int            in_issued;
    int            hold_trigger;
    int            hold_seen;
    int            hold_left;
    logic          calm;

    int4_weight_dequant_bf16_unit dut (.*);

    initial begin
        i_clk = 1'b0;
        forever #2 i_clk = ~i_clk;
    end

    task automatic report_mismatch(input string msg);
        $display("mismatch: %s", msg);
        err_count++;
    endtask

    // exact product of a small integer and an fp32 value, rounded to fp32 nearest even
    function automatic logic [31:0] scaled_fp32(input int diff, input logic [31:0] s);
        logic      sgn;
        longint    sig;
        longint    e2;
        longint    p;
        longint    q;
        longint    rem;
        longint    half;
        longint    sh;
        longint    bits;
        int        n;
        sgn = s[31] ^ (diff < 0);
        if (s[30:23] == EXP_ALL_ONES) return {sgn, 8'hFF, 23'd0};
        if (s[30:23] == 8'd0) begin
            sig = s[22:0];
            e2  = -149;
        end else begin
            sig = {1'b1, s[22:0]};
            e2  = longint'(s[30:23]) - 150;
        end
        p = (diff < 0 ? -diff : diff) * sig;
        if (p == 0) return {sgn, 31'd0};
        n = 0;
        for (int i = 0; i < 40; i++) if (p[i]) n = i;
        sh = n - 23;
        if (sh < -149 - e2) sh = -149 - e2;
        if (sh > 0) begin
            q    = p >> sh;
            rem  = p & ((64'sd1 << sh) - 1);
            half = 64'sd1 << (sh - 1);
            if (rem > half || (rem == half && q[0])) q++;
        end else begin
            q = p << (-sh);
        end
        if (sh == -149 - e2 && n - 23 < -149 - e2) bits = q;
        else bits = ((n + e2 + 127) << 23) + q - (64'sd1 << 23);
        if (bits >= 64'h7F80_0000) bits = 64'h7F80_0000;
        return {sgn, bits[30:0]};
    endfunction

    function automatic logic [2:0] awq_lane(input logic [2:0] c);
        logic [2:0] order[8] = '{3'd0, 3'd4, 3'd1, 3'd5, 3'd2, 3'd6, 3'd3, 3'd7};
        return order[c];
    endfunction

    function automatic logic [15:0] dequant_bf16(input weight_txn_t t, input logic fmt,
                                                 input logic bias);
        logic [2:0]  wpos;
        logic [2:0]  zpos;
        int          diff;
        logic [31:0] pb;
        logic [31:0] r;
        wpos = (fmt == FMT_AWQ) ? awq_lane(t.column_lane) : t.row_lane;
        zpos = (fmt == FMT_AWQ) ? awq_lane(t.column_lane) : t.column_lane;
        diff = int'(t.weight_word[wpos*4 +: 4]) - int'(t.zero_word[zpos*4 +: 4]);
        if (fmt == FMT_GPTQ) diff -= int'(bias);
        if (t.scale_bits[30:23] == EXP_ALL_ONES && t.scale_bits[22:0] != 0)
            return t.scale_bits[31:16] | BF16_QBIT;
        if (t.scale_bits[30:23] == EXP_ALL_ONES && diff == 0) return BF16_QNAN;
        pb = scaled_fp32(diff, t.scale_bits);
        r  = pb + 32'h7FFF + {31'd0, pb[16]};
        return r[31:16];
    endfunction

    function automatic logic [31:0] rand_scale();
        int          r;
        logic [7:0]  ex;
        logic [22:0] man;
        r   = $urandom_range(99);
        man = 23'($urandom);
        if (r < 70) ex = 8'($urandom_range(140, 110));
        else if (r < 75) ex = 8'd0;
        else if (r < 82) ex = 8'hFF;
        else if (r < 87) ex = 8'hFE;
        else if (r < 90) ex = 8'd1;
        else ex = 8'($urandom_range(255));
        if ($urandom_range(9) == 0) man = '0;
        return {1'($urandom), ex, man};
    endfunction

    task automatic push_weight(input logic [31:0] w, input logic [31:0] z, input logic [31:0] s,
                               input logic [2:0] c, input logic [2:0] r);
        weight_txn_t t;
        t.weight_word = w;
        t.zero_word   = z;
        t.scale_bits  = s;
        t.column_lane = c;
        t.row_lane    = r;
        pending_weights.push_back(t);
    endtask

    task automatic push_random(input int count);
        logic [31:0] w;
        for (int k = 0; k < count; k++) begin
            w = $urandom;
            // equal words give zero differences in the order-table mode
            push_weight(w, ($urandom_range(7) == 0) ? w : $urandom, rand_scale(),
                        3'($urandom_range(7)), 3'($urandom_range(7)));
        end
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic val);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        @(posedge i_clk);
        while (!o_cfg_ready) @(posedge i_clk);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_weights.size() != 0 || i_in_valid || bf16_expect.size() != 0)
            @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    // input driver
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else if (!i_in_valid || in_accepts == in_issued) begin
            if (pending_weights.size() != 0 && (calm || $urandom_range(99) >= 29)) begin
                offered = pending_weights.pop_front();
                i_weight_word <= offered.weight_word;
                i_zero_word   <= offered.zero_word;
                i_scale_bits  <= offered.scale_bits;
                i_column_lane <= offered.column_lane;
                i_row_lane    <= offered.row_lane;
                i_in_valid    <= 1'b1;
                in_issued++;
            end else begin
                i_in_valid <= 1'b0;
            end
        end
    end

    // output stall
    always @(negedge i_clk) begin
        if (hold_trigger != hold_seen) begin
            hold_seen = hold_trigger;
            hold_left = LONG_HOLD;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= !calm && ($urandom_range(99) < 29);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        weight_txn_t t;
        logic [15:0] exp_v;
        if (i_rst_n) begin
            stuck_cycles++;
            if (i_cfg_valid && o_cfg_ready) begin
                stuck_cycles = 0;
                if (i_cfg_index == CFG_FORMAT_MODE) mode_copy = i_cfg_data;
                else if (i_cfg_index == CFG_ZERO_BIAS) bias_copy = i_cfg_data;
            end
            if (i_in_valid && !o_in_stall) begin
                stuck_cycles = 0;
                t.weight_word = i_weight_word;
                t.zero_word   = i_zero_word;
                t.scale_bits  = i_scale_bits;
                t.column_lane = i_column_lane;
                t.row_lane    = i_row_lane;
                bf16_expect.push_back(dequant_bf16(t, mode_copy, bias_copy));
                in_accepts++;
            end
            if (o_out_valid && !i_out_stall) begin
                stuck_cycles = 0;
                if (bf16_expect.size() == 0) begin
                    report_mismatch($sformatf("unexpected bf16 %h", o_bf16_value));
                end else begin
                    exp_v = bf16_expect.pop_front();
                    if (exp_v !== o_bf16_value)
                        report_mismatch($sformatf("bf16 got %h want %h", o_bf16_value, exp_v));
                end
            end
        end
    end

    initial begin : watchdog
        while (stuck_cycles < STUCK_LIMIT) @(posedge i_clk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        i_rst_n = 1'b0;
        i_cfg_valid = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = 1'b0;
        i_in_valid = 1'b0;
        i_out_stall = 1'b0;
        i_weight_word = '0;
        i_zero_word = '0;
        i_scale_bits = '0;
        i_column_lane = '0;
        i_row_lane = '0;
        mode_copy = 1'b0;
        bias_copy = 1'b0;
        err_count = 0;
        stuck_cycles = 0;
        in_accepts = 0;
        in_issued = 0;
        hold_trigger = 0;
        hold_seen = 0;
        hold_left = 0;
        calm = 1'b0;
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // reset defaults, then spare indexes must drop
        write_reg(CFG_SPARE_A, 1'b1);
        write_reg(CFG_SPARE_B, 1'b1);
        push_weight('1, '0, 32'h3F80_0000, 3'd0, 3'd7);
        push_weight('0, '1, 32'h3F80_0000, 3'd7, 3'd0);
        push_weight('1, '0, 32'hBF80_0000, 3'd1, 3'd2);
        push_weight(32'h1234_5678, 32'h1234_5678, 32'h7F80_0000, 3'd3, 3'd3);
        push_weight('1, '0, 32'hFF80_0000, 3'd4, 3'd5);
        push_weight('1, '0, 32'h7FC0_0001, 3'd5, 3'd1);
        push_weight('0, '0, 32'hFFA1_2345, 3'd6, 3'd4);
        push_weight(32'hABCD_EF01, 32'hABCD_EF01, 32'hC040_0000, 3'd2, 3'd6);
        push_weight('1, '0, 32'h7F7F_FFFF, 3'd7, 3'd7);
        push_weight('0, '1, 32'h7F7F_FFFF, 3'd0, 3'd0);
        push_weight('1, '0, 32'h0000_0001, 3'd1, 3'd1);
        push_weight('0, '1, 32'h0000_0001, 3'd2, 3'd2);
        push_weight('1, '0, 32'h007F_FFFF, 3'd3, 3'd4);
        push_weight('1, '0, 32'h8000_0000, 3'd5, 3'd6);
        push_weight('1, '0, 32'h0000_0000, 3'd6, 3'd7);
        push_weight('1, '0, 32'hFFFF_FFFF, 3'd4, 3'd0);
        push_weight(32'h89AB_CDEF, 32'h0123_4567, 32'h3FFF_FFFF, 3'd7, 3'd3);
        push_weight(32'h7654_3210, 32'hFEDC_BA98, 32'h3F80_8000, 3'd0, 3'd5);
        drain();

        write_reg(CFG_FORMAT_MODE, FMT_GPTQ);
        write_reg(CFG_ZERO_BIAS, 1'b1);
        push_weight('1, '1, 32'h3F80_0000, 3'd0, 3'd7);
        push_weight('0, '0, 32'h3F80_0000, 3'd7, 3'd0);
        push_weight(32'h1000_0000, '0, 32'h7F80_0000, 3'd0, 3'd7);
        push_weight(32'h1000_0000, '0, 32'hFF80_0000, 3'd0, 3'd7);
        push_random(PHASE_ITEMS);
        wait (pending_weights.size() < 200);
        hold_trigger++;
        drain();

        write_reg(CFG_ZERO_BIAS, 1'b0);
        calm = 1'b1;
        push_random(PHASE_ITEMS);
        drain();
        calm = 1'b0;

        write_reg(CFG_FORMAT_MODE, FMT_AWQ);
        write_reg(CFG_ZERO_BIAS, 1'b1);
        push_random(PHASE_ITEMS);
        drain();

        write_reg(CFG_FORMAT_MODE, FMT_GPTQ);
        push_random(PHASE_ITEMS);
        wait (pending_weights.size() < 150);
        hold_trigger++;
        drain();
        repeat (10) @(posedge i_clk);

        if (err_count == 0 && bf16_expect.size() == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/i4dq_pkg.sv
rtl/i4dq_front.sv
rtl/i4dq_queue.sv
rtl/i4dq_back.sv
rtl/int4_weight_dequant_bf16_unit.sv
bench/testbench.sv
